/* rtl/sigmoid_top_k_selector_core_assert.svh */
// Assertion macros for the sigmoid top-k selector.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SIGMOID_TOP_K_SELECTOR_CORE_ASSERT_SVH
`define SIGMOID_TOP_K_SELECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define STK_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("stk assertion failed");

// next-cycle implication
`define STK_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("stk assertion failed");

`endif

/* rtl/stk_pkg.sv */
// Package for the sigmoid top-k selector: widths, types, register codes
// and the elaboration-time powers of exp(-1/1024) in Q1.62. No dependencies.
`default_nettype none

package stk_pkg;

  localparam int LOGIT_W        = 16;
  localparam int IDX_W          = 10;
  localparam int PROB_W         = 16;
  localparam int NK_W           = 4;
  localparam logic [NK_W-1:0] NK_RESET = 4'd5;
  localparam int MAX_KEPT_DEF    = 8;
  localparam int MAX_CLASSES_DEF = 1024;

  localparam int Q_W       = 63;
  localparam int FRAC      = 62;
  localparam int EXP_STEPS = 16;
  localparam int DIV_STEPS = 16;
  localparam int D_W       = 44;
  localparam int N_W       = 43;
  localparam int NUM_W     = 60;
  localparam int DEN_W     = 45;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_NUM_KEPT = 1'b0;

  localparam logic [63:0] Q62_ONE = 64'd1 << FRAC;

  // Taylor sum of exp(-1/1024) up to the sixth-order term, each term truncated
  localparam logic [63:0] TERM1 = Q62_ONE / 64'd1024;
  localparam logic [63:0] TERM2 = TERM1 / 64'd2048;
  localparam logic [63:0] TERM3 = TERM2 / 64'd3072;
  localparam logic [63:0] TERM4 = TERM3 / 64'd4096;
  localparam logic [63:0] TERM5 = TERM4 / 64'd5120;
  localparam logic [63:0] TERM6 = TERM5 / 64'd6144;
  localparam logic [63:0] EXP_BASE = Q62_ONE - TERM1 + TERM2 - TERM3 + TERM4 - TERM5 + TERM6;

  typedef logic [Q_W-1:0] q_t;
  typedef logic [EXP_STEPS-1:0][Q_W-1:0] exp_pow_t;

  typedef struct packed {
    logic               neg;
    logic               fe;
    logic [LOGIT_W-1:0] a;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [PROB_W-1:0] prob;
  } slot_t;

  typedef struct packed {
    logic              filled;
    logic [IDX_W-1:0]  idx;
    logic [PROB_W-1:0] prob;
  } rep_t;

  typedef struct packed {
    logic step;
    logic clear;
    logic rep_load;
    logic rep_shift;
  } cell_ctl_t;

  function automatic q_t mul_q62(q_t u, q_t v);
    logic [2*Q_W-1:0] prod;
    prod = {{Q_W{1'b0}}, u} * {{Q_W{1'b0}}, v};
    return prod[Q_W+FRAC-1:FRAC];
  endfunction

  // powers exp(-2^b/1024) by repeated squaring of the base
  function automatic exp_pow_t exp_powers();
    exp_pow_t pw;
    pw[0] = EXP_BASE[Q_W-1:0];
    for (int b = 1; b < EXP_STEPS; b++) begin
      pw[b] = mul_q62(pw[b-1], pw[b-1]);
    end
    return pw;
  endfunction

  localparam exp_pow_t EXP_POW = exp_powers();

endpackage

`default_nettype wire

/* rtl/stk_chan_if.sv */
// Stream channel interfaces for the sigmoid top-k selector.
// Depends on stk_pkg for field widths.
`default_nettype none

interface stk_in_if;
  import stk_pkg::*;
  logic               valid;
  logic               ready;
  logic [LOGIT_W-1:0] logit;
  logic               frame_end;
  modport source (output valid, logit, frame_end, input ready);
  modport sink   (input valid, logit, frame_end, output ready);
endinterface

interface stk_out_if;
  import stk_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  class_pos;
  logic [PROB_W-1:0] probability;
  logic              slot_filled;
  logic              last_of_run;
  modport source (output valid, class_pos, probability, slot_filled, last_of_run,
                  input ready);
  modport sink   (input valid, class_pos, probability, slot_filled, last_of_run,
                  output ready);
endinterface

`default_nettype wire

/* rtl/stk_exp_step.sv */
// One squaring-power step of the exp(-a/1024) pipeline: two stages,
// partial products of the 32- and 31-bit halves, then their sum. Depends on stk_pkg.
`default_nettype none

module stk_exp_step #(
  parameter int B = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire stk_pkg::item_t item_i,
  input  wire stk_pkg::q_t   res_i,
  output      logic          vld_o,
  output      stk_pkg::item_t item_o,
  output      stk_pkg::q_t   res_o
);
  import stk_pkg::*;

  localparam q_t F = EXP_POW[B];

  logic [31:0]    r0, f0;
  logic [Q_W-33:0] r1, f1;
  logic [63:0]    pp00_d, pp00_q;
  logic [62:0]    pp01_d, pp01_q, pp10_d, pp10_q;
  logic [61:0]    pp11_d, pp11_q;
  logic           vld_a_q, mul_q, vld_b_q;
  item_t          item_a_q, item_b_q;
  q_t             res_a_q, res_b_q, res_d;
  logic [63:0]    mid;
  logic [125:0]   sum;

  assign r0 = res_i[31:0];
  assign r1 = res_i[Q_W-1:32];
  assign f0 = F[31:0];
  assign f1 = F[Q_W-1:32];

  assign pp00_d = r0 * f0;
  assign pp01_d = r0 * f1;
  assign pp10_d = r1 * f0;
  assign pp11_d = r1 * f1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q   <= pp00_d;
      pp01_q   <= pp01_d;
      pp10_q   <= pp10_d;
      pp11_q   <= pp11_d;
      mul_q    <= item_i.a[B];
      item_a_q <= item_i;
      res_a_q  <= res_i;
      item_b_q <= item_a_q;
      res_b_q  <= res_d;
    end
  end

  assign mid = 64'(pp01_q) + 64'(pp10_q);
  assign sum = {pp11_q, 64'b0} + {30'b0, mid, 32'b0} + {62'b0, pp00_q};
  assign res_d = mul_q ? sum[Q_W+FRAC-1:FRAC] : res_a_q;

  assign vld_o  = vld_b_q;
  assign item_o = item_b_q;
  assign res_o  = res_b_q;

endmodule

`default_nettype wire

/* rtl/stk_div_step.sv */
// One restoring-division stage: settles quotient bit K of num / den.
// Depends on stk_pkg.
`default_nettype none

module stk_div_step #(
  parameter int K = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       vld_i,
  input  wire logic                       fe_i,
  input  wire logic [stk_pkg::NUM_W-1:0]  rem_i,
  input  wire logic [stk_pkg::DEN_W-1:0]  den_i,
  input  wire logic [stk_pkg::PROB_W-1:0] q_i,
  output      logic                       vld_o,
  output      logic                       fe_o,
  output      logic [stk_pkg::NUM_W-1:0]  rem_o,
  output      logic [stk_pkg::DEN_W-1:0]  den_o,
  output      logic [stk_pkg::PROB_W-1:0] q_o
);
  import stk_pkg::*;

  logic [NUM_W:0]    trial;
  logic              ge;
  logic [NUM_W-1:0]  rem_d, rem_q;
  logic [PROB_W-1:0] q_d, q_q;
  logic [DEN_W-1:0]  den_q;
  logic              vld_q, fe_q;

  assign trial = (NUM_W+1)'(den_i) << K;
  assign ge    = {1'b0, rem_i} >= trial;
  assign rem_d = ge ? rem_i - trial[NUM_W-1:0] : rem_i;

  always_comb begin
    q_d    = q_i;
    q_d[K] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fe_q  <= fe_i;
      rem_q <= rem_d;
      den_q <= den_i;
      q_q   <= q_d;
    end
  end

  assign vld_o = vld_q;
  assign fe_o  = fe_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign q_o   = q_q;

endmodule

`default_nettype wire

/* rtl/stk_cell.sv */
// One slot of the ranked list plus its report register; shifts to the
// next cell on insertion and towards the output on report. Depends on stk_pkg.
`default_nettype none

module stk_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire stk_pkg::cell_ctl_t ctl_i,
  input  wire logic               in_use_i,
  input  wire stk_pkg::slot_t     new_i,
  input  wire logic               found_i,
  output      logic               found_o,
  input  wire stk_pkg::slot_t     prev_i,
  output      stk_pkg::slot_t     slot_o,
  input  wire stk_pkg::rep_t      rep_next_i,
  output      stk_pkg::rep_t      rep_o
);
  import stk_pkg::*;

  slot_t slot_q, slot_d, slot_ins;
  rep_t  rep_q, rep_d;
  logic  hit;

  assign hit     = in_use_i && (!slot_q.valid || (new_i.prob > slot_q.prob));
  assign found_o = found_i || hit;

  always_comb begin
    if (hit && !found_i) begin
      slot_ins = new_i;
    end else if (found_i && in_use_i) begin
      slot_ins = prev_i;
    end else begin
      slot_ins = slot_q;
    end
    slot_d = slot_q;
    if (ctl_i.step) begin
      slot_d = ctl_i.clear ? '0 : slot_ins;
    end
  end

  always_comb begin
    rep_d = rep_q;
    if (ctl_i.rep_load) begin
      rep_d.filled = slot_ins.valid;
      rep_d.idx    = slot_ins.valid ? slot_ins.idx : '0;
      rep_d.prob   = slot_ins.valid ? slot_ins.prob : '0;
    end else if (ctl_i.rep_shift) begin
      rep_d = rep_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      rep_q  <= '0;
    end else begin
      slot_q <= slot_d;
      rep_q  <= rep_d;
    end
  end

  assign slot_o = slot_q;
  assign rep_o  = rep_q;

endmodule

`default_nettype wire

/* rtl/sigmoid_top_k_selector_core.sv */
// A frame's last logit passes the exp steps, the quotient-prep register and
// the division stages and loads the report row; results leave one per cycle
// while ready, number_kept (clamped to 1..MAX_KEPT) per frame. Logits enter
// one per cycle, but a frame end waits while the previous report row drains.
// Reset (async, active low) empties the list and report, zeroes the class
// counter and sets number_kept to 5.
`default_nettype none
`include "sigmoid_top_k_selector_core_assert.svh"

module sigmoid_top_k_selector_core #(
  parameter int MAX_KEPT    = stk_pkg::MAX_KEPT_DEF,
  parameter int MAX_CLASSES = stk_pkg::MAX_CLASSES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  stk_in_if.sink                           in_ch_i,
  stk_out_if.source                        out_ch_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [stk_pkg::APB_AW-1:0]  paddr,
  input  wire logic [stk_pkg::APB_DW-1:0]  pwdata,
  output      logic [stk_pkg::APB_DW-1:0]  prdata,
  output      logic                        pready
);
  import stk_pkg::*;

  localparam int KW = $clog2(MAX_KEPT + 1);
  localparam int CW = $clog2(MAX_CLASSES);

  // configuration
  logic [NK_W-1:0] nk_q;
  logic            reg_sel;
  logic [31:0]     nk32, kk32;
  logic [KW-1:0]   kk;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_NUM_KEPT);
  assign prdata  = reg_sel ? APB_DW'(nk_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nk_q <= NK_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      nk_q <= pwdata[NK_W-1:0];
    end
  end

  assign nk32 = 32'(nk_q);
  assign kk32 = (nk32 == 32'd0) ? 32'd1 :
                (nk32 > 32'(MAX_KEPT)) ? 32'(MAX_KEPT) : nk32;
  assign kk   = kk32[KW-1:0];

  // pipeline control
  logic en;
  logic chain_vld, chain_fe;
  logic [PROB_W-1:0] chain_p;
  logic [KW-1:0] rep_cnt_q, rep_cnt_d;

  assign en            = !(chain_vld && chain_fe && (rep_cnt_q != '0));
  assign in_ch_i.ready = en;

  // exp(-|x|/1024)
  item_t in_item;
  logic  [EXP_STEPS:0] ex_vld;
  item_t ex_item [EXP_STEPS+1];
  q_t    ex_res  [EXP_STEPS+1];

  assign in_item.neg = in_ch_i.logit[LOGIT_W-1];
  assign in_item.fe  = in_ch_i.frame_end;
  assign in_item.a   = in_ch_i.logit[LOGIT_W-1] ? (~in_ch_i.logit + 1'b1) : in_ch_i.logit;

  assign ex_vld[0]  = in_ch_i.valid;
  assign ex_item[0] = in_item;
  assign ex_res[0]  = Q62_ONE[Q_W-1:0];

  for (genvar b = 0; b < EXP_STEPS; b++) begin : g_exp
    stk_exp_step #(.B(b)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (ex_vld[b]),
      .item_i (ex_item[b]),
      .res_i  (ex_res[b]),
      .vld_o  (ex_vld[b+1]),
      .item_o (ex_item[b+1]),
      .res_o  (ex_res[b+1])
    );
  end

  // numerator and denominator of the rounded quotient
  logic [63:0]      e_sum;
  logic [D_W-1:0]   d_val;
  logic [N_W-1:0]   n_val;
  logic [NUM_W-1:0] num_d, prp_num_q;
  logic [DEN_W-1:0] den_d, prp_den_q;
  logic             prp_vld_q, prp_fe_q;

  assign e_sum = Q62_ONE + 64'(ex_res[EXP_STEPS]);
  assign d_val = e_sum[63:20];
  assign n_val = ex_item[EXP_STEPS].neg ? ex_res[EXP_STEPS][Q_W-1:20] :
                                          (N_W'(1) << (N_W-1));
  assign num_d = (NUM_W'(n_val) << 17) - (NUM_W'(n_val) << 1) + NUM_W'(d_val);
  assign den_d = {d_val, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prp_vld_q <= 1'b0;
    end else if (en) begin
      prp_vld_q <= ex_vld[EXP_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prp_fe_q  <= ex_item[EXP_STEPS].fe;
      prp_num_q <= num_d;
      prp_den_q <= den_d;
    end
  end

  // division, one quotient bit per stage
  logic [DIV_STEPS:0] dv_vld, dv_fe;
  logic [NUM_W-1:0]   dv_rem [DIV_STEPS+1];
  logic [DEN_W-1:0]   dv_den [DIV_STEPS+1];
  logic [PROB_W-1:0]  dv_q   [DIV_STEPS+1];

  assign dv_vld[0] = prp_vld_q;
  assign dv_fe[0]  = prp_fe_q;
  assign dv_rem[0] = prp_num_q;
  assign dv_den[0] = prp_den_q;
  assign dv_q[0]   = '0;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    stk_div_step #(.K(DIV_STEPS-1-s)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_vld[s]),
      .fe_i   (dv_fe[s]),
      .rem_i  (dv_rem[s]),
      .den_i  (dv_den[s]),
      .q_i    (dv_q[s]),
      .vld_o  (dv_vld[s+1]),
      .fe_o   (dv_fe[s+1]),
      .rem_o  (dv_rem[s+1]),
      .den_o  (dv_den[s+1]),
      .q_o    (dv_q[s+1])
    );
  end

  assign chain_vld = dv_vld[DIV_STEPS];
  assign chain_fe  = dv_fe[DIV_STEPS];
  assign chain_p   = dv_q[DIV_STEPS];

  // class counter
  logic [CW-1:0]       cls_q;
  logic [CW+IDX_W-1:0] cls_ext;
  cell_ctl_t           ctl;
  logic                out_fire;

  assign cls_ext = {{IDX_W{1'b0}}, cls_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= '0;
    end else if (ctl.step) begin
      if (chain_fe || (cls_q == CW'(MAX_CLASSES - 1))) begin
        cls_q <= '0;
      end else begin
        cls_q <= cls_q + 1'b1;
      end
    end
  end

  // cell row
  slot_t new_slot;
  slot_t slot_w [MAX_KEPT];
  rep_t  rep_w  [MAX_KEPT];
  logic  [MAX_KEPT:0] fnd;
  logic  [MAX_KEPT-1:0] in_use;

  assign out_fire = out_ch_o.valid && out_ch_o.ready;

  assign ctl.step      = chain_vld && en;
  assign ctl.clear     = chain_fe;
  assign ctl.rep_load  = chain_vld && en && chain_fe;
  assign ctl.rep_shift = out_fire;

  assign new_slot.valid = 1'b1;
  assign new_slot.idx   = cls_ext[IDX_W-1:0];
  assign new_slot.prob  = chain_p;

  assign fnd[0] = 1'b0;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    assign in_use[i] = (32'(i) < kk32);
    stk_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .in_use_i   (in_use[i]),
      .new_i      (new_slot),
      .found_i    (fnd[i]),
      .found_o    (fnd[i+1]),
      .prev_i     ((i == 0) ? slot_t'('0) : slot_w[(i == 0) ? 0 : i-1]),
      .slot_o     (slot_w[i]),
      .rep_next_i ((i == MAX_KEPT-1) ? rep_t'('0) : rep_w[(i == MAX_KEPT-1) ? i : i+1]),
      .rep_o      (rep_w[i])
    );
  end

  // report count
  always_comb begin
    rep_cnt_d = rep_cnt_q;
    if (ctl.rep_load) begin
      rep_cnt_d = kk;
    end else if (out_fire) begin
      rep_cnt_d = rep_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_cnt_q <= '0;
    end else begin
      rep_cnt_q <= rep_cnt_d;
    end
  end

  assign out_ch_o.valid       = (rep_cnt_q != '0);
  assign out_ch_o.class_pos   = rep_w[0].idx;
  assign out_ch_o.probability = rep_w[0].prob;
  assign out_ch_o.slot_filled = rep_w[0].filled;
  assign out_ch_o.last_of_run = (rep_cnt_q == KW'(1));

  `STK_ASSERT_IMP(a_load_into_empty, ctl.rep_load, rep_cnt_q == '0)
  `STK_ASSERT_NXT(a_run_drains, out_fire && (rep_cnt_q == KW'(1)), rep_cnt_q == '0)
  `STK_ASSERT_NXT(a_head_filled, ctl.step && !ctl.clear, slot_w[0].valid)

endmodule

`default_nettype wire

/* test/stk_rank_checker.sv */
`timescale 1ns / 1ps
// Checker for the sigmoid top-k selector: follows the config port and both
// channels, ranks logistic probabilities per frame and compares the reports.
// Depends on stk_pkg.
module stk_rank_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [stk_pkg::LOGIT_W-1:0]  logit_i,
  input  logic                         frame_end_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [stk_pkg::IDX_W-1:0]    class_pos_i,
  input  logic [stk_pkg::PROB_W-1:0]   probability_i,
  input  logic                         slot_filled_i,
  input  logic                         last_of_run_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [stk_pkg::APB_AW-1:0]   paddr_i,
  input  logic [stk_pkg::APB_DW-1:0]   pwdata_i,
  input  logic                         pready_i,
  output int unsigned                  pending_o,
  output int unsigned                  fail_count_o
);
  import stk_pkg::*;

  localparam int KEPT = MAX_KEPT_DEF;
  localparam logic [APB_AW-1:0] NUM_KEPT_ADDR = APB_AW'(4 * int'(REG_NUM_KEPT));

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [PROB_W-1:0] prob;
    logic              filled;
    logic              last;
  } ranked_class_t;

  logic [63:0]       exp_step [EXP_STEPS];
  logic [IDX_W-1:0]  kept_idx [KEPT];
  logic [PROB_W-1:0] kept_prob [KEPT];
  logic              kept_vld [KEPT];
  logic [IDX_W-1:0]  class_count;
  logic [NK_W-1:0]   num_kept;
  ranked_class_t     ranked_q [$];
  int unsigned       fails = 0;

  function automatic logic [63:0] q62_mul(logic [63:0] u, logic [63:0] v);
    logic [127:0] full;
    full = {64'd0, u} * {64'd0, v};
    return full[125:62];
  endfunction

  // exp(-2^b/1024) in Q2.62
  initial begin : build_exp_steps
    logic [63:0] term;
    logic [63:0] base;
    term = Q62_ONE;
    base = Q62_ONE;
    for (int k = 1; k <= 6; k++) begin
      term = term / (64'd1024 * 64'(k));
      if (k % 2 == 1) begin
        base = base - term;
      end else begin
        base = base + term;
      end
    end
    exp_step[0] = base;
    for (int b = 1; b < EXP_STEPS; b++) begin
      exp_step[b] = q62_mul(exp_step[b-1], exp_step[b-1]);
    end
  end

  function automatic logic [PROB_W-1:0] prob_of_logit(logic [LOGIT_W-1:0] raw);
    logic [16:0] mag;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] q;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    e = Q62_ONE;
    for (int b = 0; b < EXP_STEPS; b++) begin
      if (mag[b]) begin
        e = q62_mul(e, exp_step[b]);
      end
    end
    d = (Q62_ONE + e) >> 20;
    n = (raw[15] ? e : Q62_ONE) >> 20;
    q = (64'd131070 * n + d) / (64'd2 * d);
    return q[PROB_W-1:0];
  endfunction

  task automatic clear_ranking();
    for (int s = 0; s < KEPT; s++) begin
      kept_idx[s]  = '0;
      kept_prob[s] = '0;
      kept_vld[s]  = 1'b0;
    end
    class_count = '0;
  endtask

  task automatic rank_logit(logic [LOGIT_W-1:0] raw, logic fe);
    logic [PROB_W-1:0] p;
    ranked_class_t     r;
    int                kk;
    int                pos;
    kk  = (num_kept == 0) ? 1 : (num_kept > KEPT) ? KEPT : int'(num_kept);
    p   = prob_of_logit(raw);
    pos = kk;
    for (int s = 0; s < kk; s++) begin
      if (!kept_vld[s] || p > kept_prob[s]) begin
        pos = s;
        break;
      end
    end
    if (pos < kk) begin
      for (int j = kk - 1; j > pos; j--) begin
        kept_idx[j]  = kept_idx[j-1];
        kept_prob[j] = kept_prob[j-1];
        kept_vld[j]  = kept_vld[j-1];
      end
      kept_idx[pos]  = class_count;
      kept_prob[pos] = p;
      kept_vld[pos]  = 1'b1;
    end
    class_count = class_count + 1'b1;
    if (fe) begin
      for (int j = 0; j < kk; j++) begin
        r.idx    = kept_vld[j] ? kept_idx[j] : '0;
        r.prob   = kept_vld[j] ? kept_prob[j] : '0;
        r.filled = kept_vld[j];
        r.last   = (j == kk - 1);
        ranked_q.push_back(r);
      end
      clear_ranking();
    end
  endtask

  task automatic check_report();
    ranked_class_t r;
    if (ranked_q.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("%0t: unexpected result idx %0d prob %0d filled %0b last %0b", $realtime,
                 class_pos_i, probability_i, slot_filled_i, last_of_run_i);
      end
    end else begin
      r = ranked_q.pop_front();
      if (r.idx !== class_pos_i || r.prob !== probability_i ||
          r.filled !== slot_filled_i || r.last !== last_of_run_i) begin
        fails++;
        if (fails <= 10) begin
          $display("%0t: mismatch idx exp %0d got %0d, prob exp %0d got %0d", $realtime,
                   r.idx, class_pos_i, r.prob, probability_i);
          $display("  filled exp %0b got %0b, last exp %0b got %0b",
                   r.filled, slot_filled_i, r.last, last_of_run_i);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_ranking();
      num_kept = NK_RESET;
      ranked_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == NUM_KEPT_ADDR) begin
        num_kept = pwdata_i[NK_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        check_report();
      end
      if (in_valid_i && in_ready_i) begin
        rank_logit(logit_i, frame_end_i);
      end
    end
    pending_o    = ranked_q.size();
    fail_count_o = fails;
  end

endmodule

/* test/tb_sigmoid_top_k_selector_core.sv */
`timescale 1ns / 1ps
// Testbench top for the sigmoid top-k selector: clock, reset, logit frames,
// config writes and a stalling receiver. Depends on stk_pkg, the channel
// interfaces, the core and stk_rank_checker.
module tb_sigmoid_top_k_selector_core;
  import stk_pkg::*;

  localparam logic [APB_AW-1:0] NUM_KEPT_ADDR = APB_AW'(4 * int'(REG_NUM_KEPT));

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int unsigned       pending;
  int unsigned       fail_count;
  bit                gaps_on = 1'b0;
  bit                hold_req = 1'b0;
  int unsigned       burst_left = 0;

  stk_in_if  in_ch ();
  stk_out_if out_ch ();

  sigmoid_top_k_selector_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  stk_rank_checker i_rank_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_i    (in_ch.ready),
    .logit_i       (in_ch.logit),
    .frame_end_i   (in_ch.frame_end),
    .out_valid_i   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .class_pos_i   (out_ch.class_pos),
    .probability_i (out_ch.probability),
    .slot_filled_i (out_ch.slot_filled),
    .last_of_run_i (out_ch.last_of_run),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_sigmoid_top_k_selector_core failed");
    $finish;
  end

  // receiver: segments of differing stall patterns, one long hold on request
  initial begin : out_stall
    int mode;
    int seg;
    int hold;
    bit hold_taken;
    out_ch.ready = 1'b0;
    mode = 0;
    seg = 0;
    hold = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 3);
          seg = $urandom_range(20, 300);
        end
        seg--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= ($urandom_range(0, 6) != 0);
          default: out_ch.ready <= (seg % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_logit(input logic [LOGIT_W-1:0] l, input logic fe);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 7);
        burst_left = $urandom_range(1, 24);
        repeat (gap) begin
          @(negedge clk_i);
          in_ch.valid <= 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk_i);
    in_ch.valid     <= 1'b1;
    in_ch.logit     <= l;
    in_ch.frame_end <= fe;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain_block();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_num_kept(input logic [NK_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_KEPT_ADDR;
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [LOGIT_W-1:0] pick_logit();
    int style;
    style = $urandom_range(0, 9);
    case (style)
      0, 1, 2, 3: return LOGIT_W'($urandom);
      4, 5, 6:    return LOGIT_W'($urandom_range(0, 8191) - 4096);
      7, 8:       return ($urandom_range(0, 2) == 0) ? 16'hFF00 : 16'h0100;
      default:    return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_logit(pick_logit(), i == len - 1);
    end
  endtask

  initial begin : stimulus
    logic [NK_W-1:0] nk_plan [11];
    int              sent;
    int              len;
    nk_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd6, 4'd2, 4'd7, 4'd4, 4'd5};
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.logit     = '0;
    in_ch.frame_end = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // extremes of the logit, default list length
    send_logit(16'h7FFF, 1'b0);
    send_logit(16'h8000, 1'b0);
    send_logit(16'h0000, 1'b0);
    send_logit(16'h0001, 1'b0);
    send_logit(16'hFFFF, 1'b1);
    // frame shorter than the list: empty slots reported
    send_logit(16'h0400, 1'b0);
    send_logit(16'hFC00, 1'b1);
    // equal probabilities: arrival order, overflow dropped
    for (int i = 0; i < 7; i++) begin
      send_logit(16'h0200, i == 6);
    end
    // list length changed mid-frame, stale slots kept
    send_logit(16'h0800, 1'b0);
    send_logit(16'h0100, 1'b0);
    send_logit(16'hF000, 1'b0);
    send_logit(16'h0300, 1'b0);
    drain_block();
    write_num_kept(4'd2);
    send_logit(16'h0200, 1'b0);
    send_logit(16'h0900, 1'b0);
    drain_block();
    write_num_kept(4'd8);
    send_logit(16'h0080, 1'b1);

    for (int ph = 0; ph < 11; ph++) begin
      drain_block();
      write_num_kept(nk_plan[ph]);
      gaps_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 26) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_frame(len);
        sent += len;
      end
      if (ph == 3) begin
        // receiver holds off while short frames keep arriving back to back
        drain_block();
        write_num_kept(4'd8);
        gaps_on = 1'b0;
        hold_req = 1'b1;
        for (int f = 0; f < 40; f++) begin
          send_frame($urandom_range(1, 3));
        end
      end
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_sigmoid_top_k_selector_core passed");
    end else begin
      $display("tb_sigmoid_top_k_selector_core failed");
    end
    $finish;
  end

endmodule
